// File: hdl/iel_pkg.sv
// Shared codes and types for the positional insert/erase list.
// No dependencies; used by iel_ctrl, iel_cells and positional_insert_erase_list.
package iel_pkg;

    // Fixed field widths of the command beat and the result beat
    localparam int CMD_W   = 2;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 5;

    // Command codes (code 3 is a no-op)
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Decoded operation handed from control to the cell row and result stage
    typedef struct packed {
        logic              ins;     // shift up and load at pos
        logic              ers;     // shift down from pos
        logic              rd_ok;   // read hit, drive entry out
        logic [STAT_W-1:0] status;
    } op_t;

endpackage

// File: hdl/iel_ctrl.sv
// Range/full checks and length update for one registered command beat.
// Depends on iel_pkg.
module iel_ctrl #(
    parameter int DEPTH = 16,
    parameter int CW    = 5
) (
    input  logic [iel_pkg::CMD_W-1:0] cmd,
    input  logic [iel_pkg::POS_W-1:0] pos,
    input  logic [CW-1:0]             count,
    output iel_pkg::op_t              op,
    output logic [CW-1:0]             count_next
);

    localparam int CMPW = (CW > iel_pkg::POS_W) ? CW : iel_pkg::POS_W;

    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic            full;

    assign pos_x = CMPW'(pos);
    assign cnt_x = CMPW'(count);
    assign full  = (count == CW'(DEPTH));

    // Decode command against current length
    always_comb
    begin
        op         = '0;
        op.status  = iel_pkg::ST_OK;
        count_next = count;
        case (cmd)
            iel_pkg::CMD_INSERT:
            begin
                if (pos_x > cnt_x)
                    op.status = iel_pkg::ST_RANGE;
                else if (full)
                    op.status = iel_pkg::ST_FULL;
                else
                begin
                    op.ins     = 1'b1;
                    count_next = count + CW'(1);
                end
            end
            iel_pkg::CMD_ERASE:
            begin
                if (pos_x >= cnt_x)
                    op.status = iel_pkg::ST_RANGE;
                else
                begin
                    op.ers     = 1'b1;
                    count_next = count - CW'(1);
                end
            end
            iel_pkg::CMD_READ:
            begin
                if (pos_x >= cnt_x)
                    op.status = iel_pkg::ST_RANGE;
                else
                    op.rd_ok = 1'b1;
            end
            default:
            begin
                // unused code: no change, status ok
            end
        endcase
    end

endmodule

// File: hdl/iel_cells.sv
// Row of list cells; each cell holds, shifts up, shifts down or loads.
// Depends on iel_pkg.
module iel_cells #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                      clk,
    input  iel_pkg::op_t              op,
    input  logic [iel_pkg::POS_W-1:0] pos,
    input  logic [WIDTH-1:0]          word,
    output logic [WIDTH-1:0]          rd_word
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW = (AW + 1 > iel_pkg::POS_W) ? AW + 1 : iel_pkg::POS_W;

    logic [WIDTH-1:0] entries_reg  [DEPTH];
    logic [WIDTH-1:0] entries_next [DEPTH];
    logic [CMPW-1:0]  pos_x;
    logic [AW-1:0]    rd_idx;

    assign pos_x  = CMPW'(pos);
    assign rd_idx = AW'(pos);

    // Per-cell next value, decided from its own index vs pos
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            entries_next[i] = entries_reg[i];
            if (op.ins)
            begin
                if (CMPW'(i) == pos_x)
                    entries_next[i] = word;
                else if (CMPW'(i) > pos_x)
                    entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
            end
            else if (op.ers)
            begin
                if ((CMPW'(i) >= pos_x) && (i < DEPTH - 1))
                    entries_next[i] = entries_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    // Cell storage, payload only, no reset
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DEPTH; k++)
            entries_reg[k] <= entries_next[k];
    end

    // Read port; only used when pos is below the length
    assign rd_word = entries_reg[rd_idx];

endmodule

// File: hdl/positional_insert_erase_list.sv
// Positional insert/erase list: command register, decode and cell row, result register.
// Flow: a taken command is held in the command register; its result, decoded from it, is
// captured in the result register, which raises done.
// Throughput: one command per cycle; busy is always low, results cannot be stalled.
// Reset: rst_n clears the length and the beat flags; cell contents are undefined.
// Depends on iel_pkg, iel_ctrl, iel_cells.
module positional_insert_erase_list #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [iel_pkg::CMD_W-1:0]     command,
    input  logic [iel_pkg::POS_W-1:0]     position,
    input  logic [iel_pkg::VALUE_W-1:0]   value,
    output logic                          done,
    output logic [iel_pkg::VALUE_W-1:0]   read_value,
    output logic [iel_pkg::STAT_W-1:0]    status,
    output logic [iel_pkg::LEN_W-1:0]     length
);

    localparam int CW = $clog2(DEPTH + 1);

    // Command register
    logic                        valid_reg;
    logic [iel_pkg::CMD_W-1:0]   cmd_reg;
    logic [iel_pkg::POS_W-1:0]   pos_reg;
    logic [iel_pkg::VALUE_W-1:0] value_reg;

    // List length
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // Result register
    logic                        done_reg;
    logic [iel_pkg::VALUE_W-1:0] read_value_reg;
    logic [iel_pkg::STAT_W-1:0]  status_reg;
    logic [iel_pkg::LEN_W-1:0]   length_reg;

    iel_pkg::op_t     op_dec;
    iel_pkg::op_t     op_go;
    logic [WIDTH-1:0] rd_word;

    assign busy = 1'b0;

    // Capture beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        if (start & ~busy)
        begin
            cmd_reg   <= command;
            pos_reg   <= position;
            value_reg <= value;
        end
    end

    iel_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .cmd        (cmd_reg),
        .pos        (pos_reg),
        .count      (count_reg),
        .op         (op_dec),
        .count_next (count_next)
    );

    // Only a live beat may touch the cells
    always_comb
    begin
        op_go = op_dec;
        op_go.ins = op_dec.ins & valid_reg;
        op_go.ers = op_dec.ers & valid_reg;
    end

    iel_cells #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_cells (
        .clk     (clk),
        .op      (op_go),
        .pos     (pos_reg),
        .word    (WIDTH'(value_reg)),
        .rd_word (rd_word)
    );

    // Length and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg;
            if (valid_reg)
                count_reg <= count_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            read_value_reg <= op_dec.rd_ok ? iel_pkg::VALUE_W'(rd_word) : '0;
            status_reg     <= op_dec.status;
            length_reg     <= iel_pkg::LEN_W'(count_next);
        end
    end

    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign length     = length_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("list length above DEPTH");

    a_beat_done: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |=> done_reg)
        else $error("captured beat gave no result");

    a_count_only_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |=> count_reg == $past(count_reg))
        else $error("length changed with no beat");

    a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != iel_pkg::ST_OK) |->
            count_reg == $past(count_reg))
        else $error("failed command changed the length");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == iel_pkg::ST_FULL) |-> count_reg == CW'(DEPTH))
        else $error("full status with room left");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for positional_insert_erase_list: directed and random beats,
// predicted against a local model of the list. Depends on iel_pkg and the block's RTL.
module testbench;

    localparam int LIST_DEPTH     = 16;
    localparam int LIST_WIDTH     = 32;
    localparam int DRAIN_CYCLES   = 4;    // quiet cycles after the last result, as margin
    localparam int WATCHDOG_LIMIT = 200;  // idle cycles before the run is declared hung

    // Unused command code, treated as a no-op by the block
    localparam logic [iel_pkg::CMD_W-1:0] CMD_NOP = 2'd3;

    typedef struct packed {
        logic [iel_pkg::VALUE_W-1:0] read_value;
        logic [iel_pkg::STAT_W-1:0]  status;
        logic [iel_pkg::LEN_W-1:0]   length;
    } list_result_t;

    // DUT inputs, all known from time zero
    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [iel_pkg::CMD_W-1:0]   command = CMD_NOP;
    logic [iel_pkg::POS_W-1:0]   position = '0;
    logic [iel_pkg::VALUE_W-1:0] value = '0;
    logic                        busy;
    logic                        done;
    logic [iel_pkg::VALUE_W-1:0] read_value;
    logic [iel_pkg::STAT_W-1:0]  status;
    logic [iel_pkg::LEN_W-1:0]   length;

    // Model of the list contents
    logic [LIST_WIDTH-1:0] list_words [LIST_DEPTH];
    int                    list_len;

    list_result_t pending_results [$];
    list_result_t want;
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    bit           no_gaps = 1'b0;

    // Coverage tallies for the summary
    int n_insert = 0, n_erase = 0, n_read = 0, n_nop = 0;
    int n_range = 0, n_full = 0;

    positional_insert_erase_list #(
        .DEPTH(LIST_DEPTH),
        .WIDTH(LIST_WIDTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .position  (position),
        .value     (value),
        .done      (done),
        .read_value(read_value),
        .status    (status),
        .length    (length)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one operation to the model list and return the result it should give
    function automatic list_result_t predict_list_op(logic [iel_pkg::CMD_W-1:0] cmd,
                                                     logic [iel_pkg::POS_W-1:0] pos,
                                                     logic [iel_pkg::VALUE_W-1:0] val);
        list_result_t r;
        int           p;
        int           i;
        r = '0;
        p = pos;
        case (cmd)
            iel_pkg::CMD_INSERT:
            begin
                n_insert++;
                if (p > list_len)
                begin
                    r.status = iel_pkg::ST_RANGE;
                    n_range++;
                end
                else if (list_len >= LIST_DEPTH)
                begin
                    r.status = iel_pkg::ST_FULL;
                    n_full++;
                end
                else
                begin
                    for (i = list_len; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = val[LIST_WIDTH-1:0];
                    list_len++;
                end
            end
            iel_pkg::CMD_ERASE:
            begin
                n_erase++;
                if (p >= list_len)
                begin
                    r.status = iel_pkg::ST_RANGE;
                    n_range++;
                end
                else
                begin
                    for (i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            iel_pkg::CMD_READ:
            begin
                n_read++;
                if (p >= list_len)
                begin
                    r.status = iel_pkg::ST_RANGE;
                    n_range++;
                end
                else
                    r.read_value = list_words[p];
            end
            default:
                n_nop++;
        endcase
        r.length = iel_pkg::LEN_W'(list_len);
        return r;
    endfunction

    // Send one command beat after a random gap (none when no_gaps is set); returns at the accepting edge
    task automatic send_beat(input logic [iel_pkg::CMD_W-1:0] cmd,
                             input logic [iel_pkg::POS_W-1:0] pos,
                             input logic [iel_pkg::VALUE_W-1:0] val);
        int gap;
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                // drop start and put noise on the fields while idle
                start    <= 1'b0;
                command  <= iel_pkg::CMD_W'($urandom);
                position <= iel_pkg::POS_W'($urandom);
                value    <= $urandom;
                repeat (gap) @(posedge clk);
            end
            start    <= 1'b1;
            command  <= cmd;
            position <= pos;
            value    <= val;
            do
                @(posedge clk);
            while (busy);
            pending_results.push_back(predict_list_op(cmd, pos, val));
        end
    endtask

    // Hold off new beats until every outstanding result has come back
    task automatic drain_pause();
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while (pending_results.size() != 0);
        end
    endtask

    // Operations on an empty list, plus the unused command code
    task automatic test_empty_list();
        begin
            send_beat(iel_pkg::CMD_READ, 5'd0, 32'h0);
            send_beat(iel_pkg::CMD_ERASE, 5'd0, 32'h0);
            send_beat(iel_pkg::CMD_INSERT, 5'd1, 32'hDEADBEEF);
            send_beat(CMD_NOP, 5'd31, 32'hFFFFFFFF);
        end
    endtask

    // Fill to the limit, then hit the full and past-end cases
    task automatic test_fill_and_full();
        int k;
        logic [iel_pkg::POS_W-1:0]   p;
        logic [iel_pkg::VALUE_W-1:0] v;
        begin
            for (k = 0; k < LIST_DEPTH; k++)
            begin
                case (k % 3)
                    0: p = '0;
                    1: p = iel_pkg::POS_W'(list_len);
                    default: p = iel_pkg::POS_W'($urandom_range(0, list_len));
                endcase
                v = (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFFFFFF : $urandom;
                send_beat(iel_pkg::CMD_INSERT, p, v);
            end
            send_beat(iel_pkg::CMD_INSERT, 5'd0, $urandom);
            send_beat(iel_pkg::CMD_INSERT, 5'd16, $urandom);
            send_beat(iel_pkg::CMD_INSERT, 5'd17, $urandom);
            send_beat(iel_pkg::CMD_INSERT, 5'd31, $urandom);
        end
    endtask

    // Reads and erases at both ends and past the end of a full list
    task automatic test_read_erase_ends();
        begin
            send_beat(iel_pkg::CMD_READ, 5'd0, $urandom);
            send_beat(iel_pkg::CMD_READ, 5'd15, $urandom);
            send_beat(iel_pkg::CMD_READ, 5'd16, $urandom);
            send_beat(iel_pkg::CMD_ERASE, 5'd15, $urandom);
            send_beat(iel_pkg::CMD_ERASE, 5'd0, $urandom);
            send_beat(iel_pkg::CMD_ERASE, 5'd31, $urandom);
        end
    endtask

    // Random operations; weights in percent steer the list length up or down
    task automatic test_random_ops(input int n_beats, input int ins_pct, input int ers_pct,
                                   input bit bursty);
        int                          k;
        int                          r;
        logic [iel_pkg::CMD_W-1:0]   cmd;
        logic [iel_pkg::POS_W-1:0]   p;
        logic [iel_pkg::VALUE_W-1:0] v;
        begin
            for (k = 0; k < n_beats; k++)
            begin
                // occasional stretches with no gaps at all
                if (bursty && (k % 32 == 0))
                    no_gaps = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    cmd = iel_pkg::CMD_INSERT;
                else if (r < ins_pct + ers_pct)
                    cmd = iel_pkg::CMD_ERASE;
                else if (r < 97)
                    cmd = iel_pkg::CMD_READ;
                else
                    cmd = CMD_NOP;
                r = $urandom_range(0, 99);
                if (r < 10)
                    p = iel_pkg::POS_W'(list_len);
                else if (r < 20)
                    p = iel_pkg::POS_W'($urandom);
                else if (cmd == iel_pkg::CMD_INSERT)
                    p = iel_pkg::POS_W'($urandom_range(0, list_len));
                else
                    p = (list_len == 0) ? '0
                                        : iel_pkg::POS_W'($urandom_range(0, list_len - 1));
                r = $urandom_range(0, 19);
                v = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFFFFFF : $urandom;
                send_beat(cmd, p, v);
            end
            no_gaps = 1'b0;
        end
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat: read_value=%h status=%0d length=%0d",
                         $time, read_value, status, length);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.read_value)
                begin
                    $display("%0t: read_value mismatch: expected %h, actual %h",
                             $time, want.read_value, read_value);
                    mismatch_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, status);
                    mismatch_count++;
                end
                if (length !== want.length)
                begin
                    $display("%0t: length mismatch: expected %0d, actual %0d",
                             $time, want.length, length);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles with no beat moving either way
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, pending_results.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Test sequence
    initial
    begin
        foreach (list_words[i])
            list_words[i] = '0;
        list_len = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_fill_and_full();
        test_read_erase_ends();
        drain_pause();

        test_random_ops(250, 60, 15, 1'b1);   // grow toward full
        test_random_ops(250, 15, 60, 1'b1);   // shrink toward empty
        drain_pause();
        no_gaps = 1'b1;
        test_random_ops(200, 35, 35, 1'b0);   // back-to-back beats
        drain_pause();
        test_random_ops(400, 35, 35, 1'b1);

        // wait for the last results, then a few quiet cycles
        drain_pause();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Beats: %0d insert, %0d erase, %0d read, %0d no-op", n_insert, n_erase,
                 n_read, n_nop);
        $display("Rejected: %0d out of range, %0d insert into full list", n_range, n_full);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
